// ----- sv/sbcd_pkg.sv -----
// Shared types and constants for the SCSI block command decoder.
// Depends on nothing; the design files refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package sbcd_pkg;

  // Default buffer depth in command bytes.
  localparam int unsigned CdbMaxBytesDefault = 16;

  // The decoder reads only bytes 0 to 13 of any command block.
  localparam int unsigned CdbUsedBytes = 14;

  // Opcodes that the decoder knows.
  localparam logic [7:0] OpRead6       = 8'h08;
  localparam logic [7:0] OpWrite6      = 8'h0a;
  localparam logic [7:0] OpRead10      = 8'h28;
  localparam logic [7:0] OpWrite10     = 8'h2a;
  localparam logic [7:0] OpRead12      = 8'ha8;
  localparam logic [7:0] OpWrite12     = 8'haa;
  localparam logic [7:0] OpRead16      = 8'h88;
  localparam logic [7:0] OpWrite16     = 8'h8a;
  localparam logic [7:0] OpSyncCache   = 8'h35;
  localparam logic [7:0] OpInquiry     = 8'h12;
  localparam logic [7:0] OpReadCap10   = 8'h25;
  localparam logic [7:0] OpModeSense6  = 8'h1a;
  localparam logic [7:0] OpReadBuffer  = 8'h3c;
  localparam logic [7:0] OpVerify10    = 8'h2f;
  localparam logic [7:0] OpStartStop   = 8'h1b;
  localparam logic [7:0] OpLogSense    = 8'h4d;
  localparam logic [7:0] OpServiceIn16 = 8'h9e;

  // Field codes inside the command bytes.
  localparam logic [5:0] PageCaching   = 6'h08;
  localparam logic [5:0] PageAll       = 6'h3f;
  localparam logic [4:0] RbModeEcho    = 5'h0b;
  localparam logic [4:0] RbModeData    = 5'h02;
  localparam logic [4:0] RbModeCombHdr = 5'h00;
  localparam logic [4:0] RbModeVendor  = 5'h01;
  localparam logic [4:0] RbModeDesc    = 5'h03;
  localparam logic [4:0] RbModeEchoDat = 5'h0a;
  localparam logic [4:0] RbModeErrHist = 5'h1a;
  localparam logic [4:0] RbModeErrAlt  = 5'h1c;
  localparam logic [4:0] SaReadCap16   = 5'h10;

  // Largest 32-bit block address.
  localparam logic [31:0] Cap32Max = 32'hffff_ffff;

  // Command classes found by the front part.
  typedef enum logic [3:0] {
    CmdRw6,
    CmdRw10,
    CmdRw12,
    CmdRw16,
    CmdSync,
    CmdInquiry,
    CmdCap10,
    CmdModeSense,
    CmdReadBuffer,
    CmdGood,
    CmdLogSense,
    CmdServiceIn,
    CmdIllegal
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ActRead  = 3'd0,
    ActWrite = 3'd1,
    ActFlush = 3'd2,
    ActGood  = 3'd3,
    ActCheck = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ErrNone       = 2'd0,
    ErrIllegalOp  = 2'd1,
    ErrInvalidFld = 2'd2,
    ErrOutOfRange = 2'd3
  } error_e;

  typedef enum logic [2:0] {
    RepNone       = 3'd0,
    RepInquiry    = 3'd1,
    RepCapacity10 = 3'd2,
    RepModeHeader = 3'd3,
    RepModeCache  = 3'd4,
    RepEchoDesc   = 3'd5,
    RepLogPages   = 3'd6,
    RepCapacity16 = 3'd7
  } reply_e;

  typedef logic [CdbUsedBytes-1:0][7:0] cdb_bytes_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    cmd_kind_e  kind;
    logic       is_write;
    cdb_bytes_t bytes;
  } cmd_t;

  // Queue head as the back part sees it.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// ----- sv/sbcd_front.sv -----
// Front part: collects command bytes beat by beat and classifies the opcode.
// Depends on sbcd_pkg; hands one classified command to the queue per last byte.
`timescale 1ns / 1ps

module sbcd_front #(
  parameter int unsigned CDB_MAX_BYTES = sbcd_pkg::CdbMaxBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        cdb_byte_i,
  input  logic              last_byte_i,
  output logic              push_o,
  output sbcd_pkg::cmd_t    cmd_o
);

  localparam int unsigned PosW = $clog2(CDB_MAX_BYTES + 1);

  logic [PosW-1:0]      pos_q, pos_d;
  sbcd_pkg::cdb_bytes_t bytes_q, bytes_d;
  sbcd_pkg::cdb_bytes_t snap;

  // Current buffer with this beat's byte merged in at its position.
  always_comb begin
    for (int i = 0; i < int'(sbcd_pkg::CdbUsedBytes); i++) begin
      snap[i] = (pos_q == PosW'(i)) ? cdb_byte_i : bytes_q[i];
    end
  end

  // Opcode classification.
  always_comb begin
    cmd_o.bytes    = snap;
    // Every write opcode here has bit 1 set, every read opcode has it clear.
    cmd_o.is_write = snap[0][1];
    unique case (snap[0]) inside
      sbcd_pkg::OpRead6, sbcd_pkg::OpWrite6:     cmd_o.kind = sbcd_pkg::CmdRw6;
      sbcd_pkg::OpRead10, sbcd_pkg::OpWrite10:   cmd_o.kind = sbcd_pkg::CmdRw10;
      sbcd_pkg::OpRead12, sbcd_pkg::OpWrite12:   cmd_o.kind = sbcd_pkg::CmdRw12;
      sbcd_pkg::OpRead16, sbcd_pkg::OpWrite16:   cmd_o.kind = sbcd_pkg::CmdRw16;
      sbcd_pkg::OpSyncCache:                     cmd_o.kind = sbcd_pkg::CmdSync;
      sbcd_pkg::OpInquiry:                       cmd_o.kind = sbcd_pkg::CmdInquiry;
      sbcd_pkg::OpReadCap10:                     cmd_o.kind = sbcd_pkg::CmdCap10;
      sbcd_pkg::OpModeSense6:                    cmd_o.kind = sbcd_pkg::CmdModeSense;
      sbcd_pkg::OpReadBuffer:                    cmd_o.kind = sbcd_pkg::CmdReadBuffer;
      sbcd_pkg::OpVerify10, sbcd_pkg::OpStartStop: cmd_o.kind = sbcd_pkg::CmdGood;
      sbcd_pkg::OpLogSense:                      cmd_o.kind = sbcd_pkg::CmdLogSense;
      sbcd_pkg::OpServiceIn16:                   cmd_o.kind = sbcd_pkg::CmdServiceIn;
      default:                                   cmd_o.kind = sbcd_pkg::CmdIllegal;
    endcase
  end

  assign push_o = accept_i & last_byte_i;

  // Buffer update: store the beat, or clear everything after the last byte.
  always_comb begin
    bytes_d = bytes_q;
    pos_d   = pos_q;
    if (accept_i) begin
      if (last_byte_i) begin
        bytes_d = '0;
        pos_d   = '0;
      end else begin
        bytes_d = snap;
        if (pos_q < PosW'(CDB_MAX_BYTES)) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bytes_q <= '0;
    end else begin
      pos_q   <= pos_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

// ----- sv/sbcd_queue.sv -----
// Two-entry queue of classified commands between the front and back parts.
// Depends on sbcd_pkg for the command record.
`timescale 1ns / 1ps

module sbcd_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sbcd_pkg::cmd_t          cmd_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output sbcd_pkg::queue_head_t   head_o
);

  sbcd_pkg::cmd_t entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = entries_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- sv/sbcd_back.sv -----
// Back part: decodes fields of a classified command, checks the block range
// and holds the result in an output register. Depends on sbcd_pkg.
`timescale 1ns / 1ps

module sbcd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [63:0]           disk_sectors_i,
  input  sbcd_pkg::queue_head_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            action_o,
  output logic [1:0]            error_kind_o,
  output logic [2:0]            reply_kind_o,
  output logic [63:0]           start_block_o,
  output logic [31:0]           block_count_o,
  output logic [63:0]           capacity_value_o
);

  sbcd_pkg::cdb_bytes_t b;
  logic [63:0] start;
  logic [31:0] count;
  logic [64:0] end_sum;
  logic        out_of_range;
  logic        is_xfer;
  logic [63:0] disk_minus1;
  logic [4:0]  rb_mode;

  sbcd_pkg::action_e act_d;
  sbcd_pkg::error_e  err_d;
  sbcd_pkg::reply_e  rep_d;
  logic [63:0] start_d, cap_d;
  logic [31:0] count_d;

  logic        out_valid_q, out_valid_d;
  sbcd_pkg::action_e act_q;
  sbcd_pkg::error_e  err_q;
  sbcd_pkg::reply_e  rep_q;
  logic [63:0] start_q, cap_q;
  logic [31:0] count_q;

  assign b       = head_i.cmd.bytes;
  assign rb_mode = b[1][4:0];

  // Start block and count of the transfer forms.
  always_comb begin
    start   = '0;
    count   = '0;
    is_xfer = 1'b1;
    case (head_i.cmd.kind)
      sbcd_pkg::CmdRw6: begin
        start = {43'd0, b[1][4:0], b[2], b[3]};
        // A zero length in the six-byte form means 256 blocks.
        count = (b[4] == 8'd0) ? 32'd256 : {24'd0, b[4]};
      end
      sbcd_pkg::CmdRw10: begin
        start = {32'd0, b[2], b[3], b[4], b[5]};
        count = {16'd0, b[7], b[8]};
      end
      sbcd_pkg::CmdRw12: begin
        start = {32'd0, b[2], b[3], b[4], b[5]};
        count = {b[6], b[7], b[8], b[9]};
      end
      sbcd_pkg::CmdRw16: begin
        start = {b[2], b[3], b[4], b[5], b[6], b[7], b[8], b[9]};
        count = {b[10], b[11], b[12], b[13]};
      end
      default: is_xfer = 1'b0;
    endcase
  end

  // Range check on the exact 65-bit end address.
  assign end_sum      = {1'b0, start} + {33'd0, count};
  assign out_of_range = end_sum > {1'b0, disk_sectors_i};
  assign disk_minus1  = disk_sectors_i - 64'd1;

  // Result decode.
  always_comb begin
    act_d   = sbcd_pkg::ActGood;
    err_d   = sbcd_pkg::ErrNone;
    rep_d   = sbcd_pkg::RepNone;
    start_d = '0;
    count_d = '0;
    cap_d   = '0;
    unique case (head_i.cmd.kind)
      sbcd_pkg::CmdSync: act_d = sbcd_pkg::ActFlush;
      sbcd_pkg::CmdInquiry: rep_d = sbcd_pkg::RepInquiry;
      sbcd_pkg::CmdCap10: begin
        rep_d = sbcd_pkg::RepCapacity10;
        // Large disks saturate the 32-bit last block address.
        cap_d = (disk_sectors_i > {32'd0, sbcd_pkg::Cap32Max}) ?
                {32'd0, sbcd_pkg::Cap32Max} : {32'd0, disk_minus1[31:0]};
      end
      sbcd_pkg::CmdModeSense: begin
        rep_d = (b[2][5:0] == sbcd_pkg::PageCaching || b[2][5:0] == sbcd_pkg::PageAll) ?
                sbcd_pkg::RepModeCache : sbcd_pkg::RepModeHeader;
      end
      sbcd_pkg::CmdReadBuffer: begin
        case (rb_mode) inside
          sbcd_pkg::RbModeEcho: rep_d = sbcd_pkg::RepEchoDesc;
          sbcd_pkg::RbModeCombHdr, sbcd_pkg::RbModeVendor, sbcd_pkg::RbModeData,
          sbcd_pkg::RbModeDesc, sbcd_pkg::RbModeEchoDat, sbcd_pkg::RbModeErrHist,
          sbcd_pkg::RbModeErrAlt: rep_d = sbcd_pkg::RepNone;
          default: begin
            act_d = sbcd_pkg::ActCheck;
            err_d = sbcd_pkg::ErrInvalidFld;
          end
        endcase
      end
      sbcd_pkg::CmdGood: rep_d = sbcd_pkg::RepNone;
      sbcd_pkg::CmdLogSense: begin
        if (b[2][5:0] == 6'd0 && b[3] == 8'd0) begin
          rep_d = sbcd_pkg::RepLogPages;
        end else begin
          act_d = sbcd_pkg::ActCheck;
          err_d = sbcd_pkg::ErrInvalidFld;
        end
      end
      sbcd_pkg::CmdServiceIn: begin
        if (b[1][4:0] == sbcd_pkg::SaReadCap16) begin
          rep_d = sbcd_pkg::RepCapacity16;
          cap_d = disk_minus1;
        end else begin
          act_d = sbcd_pkg::ActCheck;
          err_d = sbcd_pkg::ErrInvalidFld;
        end
      end
      sbcd_pkg::CmdRw6, sbcd_pkg::CmdRw10, sbcd_pkg::CmdRw12, sbcd_pkg::CmdRw16: begin
        start_d = start;
        count_d = count;
        if (out_of_range) begin
          act_d = sbcd_pkg::ActCheck;
          err_d = sbcd_pkg::ErrOutOfRange;
        end else begin
          act_d = head_i.cmd.is_write ? sbcd_pkg::ActWrite : sbcd_pkg::ActRead;
        end
      end
      default: begin
        act_d = sbcd_pkg::ActCheck;
        err_d = sbcd_pkg::ErrIllegalOp;
      end
    endcase
    if (!is_xfer) begin
      start_d = '0;
      count_d = '0;
    end
  end

  // Output register: refill whenever it is empty or being taken.
  assign pop_o       = head_i.valid & (~out_valid_q | ~out_stall_i);
  assign out_valid_d = pop_o | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      act_q   <= act_d;
      err_q   <= err_d;
      rep_q   <= rep_d;
      start_q <= start_d;
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign action_o         = act_q;
  assign error_kind_o     = err_q;
  assign reply_kind_o     = rep_q;
  assign start_block_o    = start_q;
  assign block_count_o    = count_q;
  assign capacity_value_o = cap_q;

endmodule

// ----- sv/scsi_block_command_decoder.sv -----
// Top level of the SCSI block command decoder: disk size register, front,
// queue and back parts. Depends on sbcd_pkg, sbcd_front, sbcd_queue, sbcd_back.
`timescale 1ns / 1ps
//
// Usage:
// The input channel carries one command byte per beat (cdb_byte_i) with
// last_byte_i marking the final byte of a command block. Each last byte
// yields exactly one result beat on the output channel; other bytes yield
// none. The configuration channel writes the disk size in sectors; it is
// always ready and should be written only while no command is in flight.
// Throughput is one byte per cycle while in_stall_o is low. The edge that
// accepts a last byte writes its command into the two-entry command queue;
// the output register loads it from the queue head when the register is
// empty or being taken. When the output is stalled the result holds; the
// queue then absorbs up to two further commands, and in_stall_o rises only
// when the queue is full. Reset clears the byte buffer, the queue and the
// output valid, and sets the disk size to zero.
//

module scsi_block_command_decoder #(
  parameter int unsigned CDB_MAX_BYTES = sbcd_pkg::CdbMaxBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  cdb_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [1:0]  error_kind_o,
  output logic [2:0]  reply_kind_o,
  output logic [63:0] start_block_o,
  output logic [31:0] block_count_o,
  output logic [63:0] capacity_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_disk_sectors_i
);

  logic [63:0]           disk_sectors_q;
  logic                  in_accept;
  logic                  push;
  logic                  full;
  logic                  pop;
  sbcd_pkg::cmd_t        cmd;
  sbcd_pkg::queue_head_t head;

  // Disk size register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_sectors_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      disk_sectors_q <= cfg_disk_sectors_i;
    end
  end

  assign in_stall_o = full;
  assign in_accept  = in_valid_i & ~in_stall_o;

  sbcd_front #(
    .CDB_MAX_BYTES(CDB_MAX_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .cdb_byte_i  (cdb_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  sbcd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  sbcd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .disk_sectors_i   (disk_sectors_q),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .error_kind_o     (error_kind_o),
    .reply_kind_o     (reply_kind_o),
    .start_block_o    (start_block_o),
    .block_count_o    (block_count_o),
    .capacity_value_o (capacity_value_o)
  );

endmodule

// ----- dv/tb.sv -----
// Testbench for the SCSI block command decoder: directed and random command blocks,
// checked beat by beat against a behavioral decoder kept inside the bench.
// Depends on sbcd_pkg and scsi_block_command_decoder.
`timescale 1ns / 1ps

module tb;
  import sbcd_pkg::*;

  localparam int unsigned CdbDepth   = CdbMaxBytesDefault;
  localparam int unsigned MaxCmdLen  = 20;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 110;
  localparam int unsigned SetSize    = 12;

  localparam logic [7:0] KnownOps [17] = '{
    OpRead6, OpWrite6, OpRead10, OpWrite10, OpRead12, OpWrite12, OpRead16, OpWrite16,
    OpSyncCache, OpInquiry, OpReadCap10, OpModeSense6, OpReadBuffer, OpVerify10,
    OpStartStop, OpLogSense, OpServiceIn16
  };

  // Status that one command block is expected to complete with.
  typedef struct {
    action_e     act;
    error_e      err;
    reply_e      rep;
    logic [63:0] lba;
    logic [31:0] blocks;
    logic [63:0] last_lba;
  } cmd_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  cdb_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [1:0]  error_kind;
  logic [2:0]  reply_kind;
  logic [63:0] start_block;
  logic [31:0] block_count;
  logic [63:0] capacity_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_sectors = '0;

  // Bench copy of the decoder state.
  logic [7:0]  cdb_store [CdbDepth];
  int unsigned cdb_fill;
  logic [63:0] sectors_model = '0;
  cmd_status_t expected_status [$];
  cmd_status_t want_status;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  event hold_ev;

  int failures = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int cfg_writes = 0;
  int held_input_cycles = 0;
  int unsigned cycle_cnt = 0;

  scsi_block_command_decoder u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .cdb_byte_i         (cdb_byte),
    .last_byte_i        (last_byte),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .action_o           (action),
    .error_kind_o       (error_kind),
    .reply_kind_o       (reply_kind),
    .start_block_o      (start_block),
    .block_count_o      (block_count),
    .capacity_value_o   (capacity_value),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_disk_sectors_i (cfg_sectors)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run-time guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stall: random, or held high for a long stretch on request.
  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  initial begin
    forever begin
      @(hold_ev);
      rx_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_stall) held_input_cycles++;
  end

  // Decode a completed command block with the bench state.
  function automatic cmd_status_t decode_command();
    cmd_status_t s;
    logic        is_xfer;
    logic        is_wr;
    logic [4:0]  sub5;
    logic [64:0] span;
    s.act = ActGood;
    s.err = ErrNone;
    s.rep = RepNone;
    s.lba = '0;
    s.blocks = '0;
    s.last_lba = '0;
    is_xfer = 1'b0;
    is_wr = 1'b0;
    case (cdb_store[0])
      OpRead6, OpWrite6: begin
        is_xfer = 1'b1;
        is_wr = (cdb_store[0] == OpWrite6);
        s.lba = {43'd0, cdb_store[1][4:0], cdb_store[2], cdb_store[3]};
        // A six-byte length of zero stands for 256 blocks.
        s.blocks = (cdb_store[4] == 8'h00) ? 32'd256 : {24'd0, cdb_store[4]};
      end
      OpRead10, OpWrite10: begin
        is_xfer = 1'b1;
        is_wr = (cdb_store[0] == OpWrite10);
        s.lba = {32'd0, cdb_store[2], cdb_store[3], cdb_store[4], cdb_store[5]};
        s.blocks = {16'd0, cdb_store[7], cdb_store[8]};
      end
      OpRead12, OpWrite12: begin
        is_xfer = 1'b1;
        is_wr = (cdb_store[0] == OpWrite12);
        s.lba = {32'd0, cdb_store[2], cdb_store[3], cdb_store[4], cdb_store[5]};
        s.blocks = {cdb_store[6], cdb_store[7], cdb_store[8], cdb_store[9]};
      end
      OpRead16, OpWrite16: begin
        is_xfer = 1'b1;
        is_wr = (cdb_store[0] == OpWrite16);
        s.lba = {cdb_store[2], cdb_store[3], cdb_store[4], cdb_store[5],
                 cdb_store[6], cdb_store[7], cdb_store[8], cdb_store[9]};
        s.blocks = {cdb_store[10], cdb_store[11], cdb_store[12], cdb_store[13]};
      end
      OpSyncCache: s.act = ActFlush;
      OpInquiry: s.rep = RepInquiry;
      OpReadCap10: begin
        s.rep = RepCapacity10;
        s.last_lba = (sectors_model > 64'hffff_ffff) ? {32'd0, Cap32Max}
                                                     : {32'd0, sectors_model[31:0] - 32'd1};
      end
      OpModeSense6: begin
        s.rep = (cdb_store[2][5:0] == PageCaching || cdb_store[2][5:0] == PageAll)
                ? RepModeCache : RepModeHeader;
      end
      OpReadBuffer: begin
        sub5 = cdb_store[1][4:0];
        if (sub5 == RbModeEcho) begin
          s.rep = RepEchoDesc;
        end else if (!(sub5 <= RbModeDesc || sub5 == RbModeEchoDat ||
                       sub5 == RbModeErrHist || sub5 == RbModeErrAlt)) begin
          s.act = ActCheck;
          s.err = ErrInvalidFld;
        end
      end
      OpVerify10, OpStartStop: ;
      OpLogSense: begin
        if (cdb_store[2][5:0] == 6'd0 && cdb_store[3] == 8'h00) begin
          s.rep = RepLogPages;
        end else begin
          s.act = ActCheck;
          s.err = ErrInvalidFld;
        end
      end
      OpServiceIn16: begin
        if (cdb_store[1][4:0] == SaReadCap16) begin
          s.rep = RepCapacity16;
          s.last_lba = sectors_model - 64'd1;
        end else begin
          s.act = ActCheck;
          s.err = ErrInvalidFld;
        end
      end
      default: begin
        s.act = ActCheck;
        s.err = ErrIllegalOp;
      end
    endcase
    // The range check is done in 65 bits so that no sum wraps.
    if (is_xfer) begin
      span = {1'b0, s.lba} + {33'd0, s.blocks};
      if (span > {1'b0, sectors_model}) begin
        s.act = ActCheck;
        s.err = ErrOutOfRange;
      end else begin
        s.act = is_wr ? ActWrite : ActRead;
      end
    end
    return s;
  endfunction

  // Store one accepted byte; the last byte of a block yields one status.
  task automatic capture_byte(input logic [7:0] b, input logic is_last);
    if (cdb_fill < CdbDepth) begin
      cdb_store[cdb_fill] = b;
      cdb_fill++;
    end
    if (is_last) begin
      expected_status.push_back(decode_command());
      foreach (cdb_store[i]) cdb_store[i] = 8'h00;
      cdb_fill = 0;
    end
  endtask

  // Offer one byte and wait until it is taken.
  task automatic push_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cdb_byte <= b;
    last_byte <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    capture_byte(b, is_last);
    bytes_sent++;
  endtask

  // Send a command block; byte 0 sits in the most significant used byte.
  task automatic send_cmd(input logic [8*MaxCmdLen-1:0] bytes, input int n);
    for (int i = 0; i < n; i++) begin
      push_byte(bytes[8*(n-1-i) +: 8], i == n - 1);
    end
  endtask

  // Wait until every pending status has come back and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_disk_size(input logic [63:0] sectors);
    settle();
    cfg_valid <= 1'b1;
    cfg_sectors <= sectors;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sectors_model = sectors;
    cfg_writes++;
  endtask

  // Compare each result beat with the oldest pending status.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $error("result beat with no command pending");
        failures++;
      end else begin
        want_status = expected_status.pop_front();
        results_checked++;
        if (action !== want_status.act) begin
          $error("action: expected %0d, got %0d", want_status.act, action);
          failures++;
        end
        if (error_kind !== want_status.err) begin
          $error("error_kind: expected %0d, got %0d", want_status.err, error_kind);
          failures++;
        end
        if (reply_kind !== want_status.rep) begin
          $error("reply_kind: expected %0d, got %0d", want_status.rep, reply_kind);
          failures++;
        end
        if (start_block !== want_status.lba) begin
          $error("start_block: expected %h, got %h", want_status.lba, start_block);
          failures++;
        end
        if (block_count !== want_status.blocks) begin
          $error("block_count: expected %h, got %h", want_status.blocks, block_count);
          failures++;
        end
        if (capacity_value !== want_status.last_lba) begin
          $error("capacity_value: expected %h, got %h", want_status.last_lba,
                 capacity_value);
          failures++;
        end
      end
    end
  end

  // Reads and writes of every form, in range, on the boundary and past it.
  task automatic test_transfer_commands();
    set_disk_size(64'd1000);
    send_cmd({OpRead6, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00}, 6);
    send_cmd({OpWrite6, 8'he0, 8'h02, 8'he8, 8'h00, 8'hff}, 6);
    send_cmd({OpRead10, 8'h00, 32'd999, 8'h00, 16'd1, 8'h00}, 10);
    send_cmd({OpWrite10, 8'hff, 32'd999, 8'hff, 16'd2, 8'hff}, 10);
    send_cmd({OpWrite12, 8'h00, 32'd0, 32'd1000, 8'h00, 8'h00}, 12);
    send_cmd({OpRead12, 8'h00, 32'd1, 32'd1000, 8'h00, 8'h00}, 12);
    send_cmd({OpRead16, 8'h00, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 16'h0}, 16);
    send_cmd({OpWrite16, 8'h00, 64'd0, 32'd0, 16'h0}, 16);
    set_disk_size('1);
    send_cmd({OpWrite16, 8'h00, 64'hffff_ffff_ffff_fffe, 32'd1, 16'hffff}, 16);
    send_cmd({OpRead16, 8'h00, 64'hffff_ffff_ffff_ffff, 32'd1, 16'h0}, 16);
  endtask

  // Flush, inquiry, capacity, verify, start-stop, mode sense, read buffer, log sense and unknown opcodes.
  task automatic test_informational_commands();
    set_disk_size(64'd0);
    send_cmd({OpReadCap10, 72'h0}, 10);
    send_cmd({OpServiceIn16, 3'b111, SaReadCap16, 112'h0}, 16);
    set_disk_size(64'd1);
    send_cmd({OpReadCap10, 72'h0}, 10);
    send_cmd({OpServiceIn16, 3'b000, SaReadCap16, 112'h0}, 16);
    set_disk_size(64'hffff_ffff);
    send_cmd({OpReadCap10, 72'h0}, 10);
    set_disk_size(64'h1_0000_0000);
    send_cmd({OpReadCap10, 72'h0}, 10);
    send_cmd({OpServiceIn16, 3'b000, 5'h11, 112'h0}, 16);
    send_cmd({OpSyncCache, 72'h0}, 10);
    send_cmd({OpInquiry, 40'h0}, 6);
    send_cmd({OpVerify10, 72'h0}, 10);
    send_cmd({OpStartStop, 40'hff_ffff_ffff}, 6);
    send_cmd({OpModeSense6, 8'h00, 2'b11, PageCaching, 24'h0}, 6);
    send_cmd({OpModeSense6, 8'h00, 2'b00, PageAll, 24'h0}, 6);
    send_cmd({OpModeSense6, 8'h00, 2'b01, 6'h1c, 24'h0}, 6);
    send_cmd({OpReadBuffer, 3'b101, RbModeEcho, 64'h0}, 10);
    send_cmd({OpReadBuffer, 3'b000, RbModeErrAlt, 64'h0}, 10);
    send_cmd({OpReadBuffer, 3'b000, 5'h04, 64'h0}, 10);
    send_cmd({OpLogSense, 8'h00, 2'b11, 6'h00, 8'h00, 48'h0}, 10);
    send_cmd({OpLogSense, 8'h00, 2'b00, 6'h01, 8'h00, 48'h0}, 10);
    send_cmd({OpLogSense, 8'h00, 2'b00, 6'h00, 8'h01, 48'h0}, 10);
    send_cmd({8'h00, 40'h0}, 6);
    send_cmd({8'hff, 8'hff}, 2);
  endtask

  // Blocks cut short read as zero; bytes past the buffer are dropped.
  task automatic test_block_lengths();
    set_disk_size(64'd300);
    send_cmd({OpRead10}, 1);
    send_cmd({OpRead6}, 1);
    send_cmd({OpModeSense6, 8'h00}, 2);
    send_cmd({OpWrite16, {19{8'hff}}}, 20);
    send_cmd({OpWrite16, 8'h00, 64'd44, 32'd5, 8'h00, 8'h00, 32'hffff_ffff}, 20);
  endtask

  function automatic logic [63:0] pick_disk_size();
    case ($urandom_range(4))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(4096));
      2: return {32'd0, $urandom};
      3: return 64'h1_0000_0000 - 64'($urandom_range(2));
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  // One command of random content; transfers aim near the end of the disk.
  task automatic random_command();
    logic [7:0]              raw [MaxCmdLen];
    logic [8*MaxCmdLen-1:0]  cdb_vec;
    logic [7:0]              op;
    logic [63:0]             lba;
    logic [63:0]             room;
    logic [31:0]             blocks;
    int                      len;
    foreach (raw[i]) raw[i] = 8'($urandom);
    op = KnownOps[$urandom_range(16)];
    if ($urandom_range(7) == 0) op = 8'($urandom);
    raw[0] = op;
    // Length follows the opcode group; a few blocks are cut short or run long.
    case (op[7:5])
      3'd0: len = 6;
      3'd4: len = 16;
      3'd5: len = 12;
      default: len = 10;
    endcase
    if ($urandom_range(9) == 0) len = $urandom_range(1, MaxCmdLen);
    case ($urandom_range(3))
      0: lba = {$urandom, $urandom};
      1: lba = (sectors_model == '1) ? {$urandom, $urandom}
                                     : {$urandom, $urandom} % (sectors_model + 64'd1);
      2: lba = sectors_model - 64'($urandom_range(20));
      default: lba = '0;
    endcase
    if (op == OpRead6 || op == OpWrite6) lba[63:21] = '0;
    else if (op[7:5] != 3'd4) lba[63:32] = '0;
    room = sectors_model - lba;
    case ($urandom_range(3))
      0: blocks = $urandom_range(16);
      1: blocks = $urandom;
      2: blocks = room[31:0];
      default: blocks = room[31:0] + 32'd1;
    endcase
    case (op)
      OpRead6, OpWrite6: begin
        raw[1][4:0] = lba[20:16];
        {raw[2], raw[3]} = lba[15:0];
        raw[4] = blocks[7:0];
      end
      OpRead10, OpWrite10: begin
        {raw[2], raw[3], raw[4], raw[5]} = lba[31:0];
        {raw[7], raw[8]} = blocks[15:0];
      end
      OpRead12, OpWrite12: begin
        {raw[2], raw[3], raw[4], raw[5]} = lba[31:0];
        {raw[6], raw[7], raw[8], raw[9]} = blocks;
      end
      OpRead16, OpWrite16: begin
        {raw[2], raw[3], raw[4], raw[5], raw[6], raw[7], raw[8], raw[9]} = lba;
        {raw[10], raw[11], raw[12], raw[13]} = blocks;
      end
      OpModeSense6: if ($urandom_range(1)) raw[2][5:0] = $urandom_range(1) ? PageCaching : PageAll;
      OpLogSense: begin
        if ($urandom_range(1)) begin
          raw[2][5:0] = 6'd0;
          raw[3] = 8'h00;
        end
      end
      OpServiceIn16: if ($urandom_range(1)) raw[1][4:0] = SaReadCap16;
      default: ;
    endcase
    cdb_vec = '0;
    for (int i = 0; i < len; i++) cdb_vec[8*(len-1-i) +: 8] = raw[i];
    send_cmd(cdb_vec, len);
  endtask

  // Random traffic in sets, each set under a fresh disk size.
  task automatic test_random_traffic();
    int start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < PhaseBytes) begin
      set_disk_size(pick_disk_size());
      repeat (SetSize) random_command();
    end
  endtask

  // Hold the output for a long stretch while short commands keep coming.
  task automatic test_input_backpressure();
    set_disk_size(64'd4096);
    -> hold_ev;
    for (int i = 0; i < 30; i++) begin
      send_cmd({($urandom_range(1) ? OpInquiry : OpSyncCache)}, 1);
    end
    settle();
  endtask

  initial begin
    foreach (cdb_store[i]) cdb_store[i] = 8'h00;
    cdb_fill = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 31;
    rx_idle_pct = 84;
    test_transfer_commands();
    test_informational_commands();
    test_block_lengths();
    test_random_traffic();

    tx_idle_pct = 84;
    rx_idle_pct = 31;
    test_random_traffic();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic();
    test_input_backpressure();
    settle();

    $display("Sent %0d command bytes under %0d disk sizes; checked %0d status beats.",
             bytes_sent, cfg_writes, results_checked);
    $display("Input was held off for %0d cycles by output back-pressure.",
             held_input_cycles);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
